// ===== hdl/ehe_pkg.sv =====
// Shared types, character codes and the entity text table for the HTML entity escaper.
// No dependencies.
`default_nettype none

package ehe_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_LEAD  = 8'hC3;
    localparam logic [7:0] CH_A_ACU = 8'hA1;
    localparam logic [7:0] CH_E_ACU = 8'hA9;
    localparam logic [7:0] CH_I_ACU = 8'hAD;
    localparam logic [7:0] CH_O_ACU = 8'hB3;
    localparam logic [7:0] CH_U_ACU = 8'hBA;
    localparam logic [7:0] CH_N_TIL = 8'hB1;
    localparam logic [7:0] CH_N_TUC = 8'h91;

    typedef enum logic [3:0] {
        ENT_AMP,
        ENT_LT,
        ENT_GT,
        ENT_QUOT,
        ENT_APOS,
        ENT_AACUTE,
        ENT_EACUTE,
        ENT_IACUTE,
        ENT_OACUTE,
        ENT_UACUTE,
        ENT_NTILDE,
        ENT_NTILDE_UC
    } ent_id_t;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_BYTE,
        BODY_ENT
    } body_kind_t;

    // One queued output run: optional leading 0xC3, body, optional trailing 0xC3.
    typedef struct packed {
        logic       pre;
        logic       post;
        body_kind_t kind;
        ent_id_t    ent;
        logic [7:0] data;
    } run_t;

    // Entity text, left aligned, zero padded.
    function automatic logic [63:0] ent_text(ent_id_t id);
        case (id)
            ENT_AMP:       return {"&amp;", 24'h0};
            ENT_LT:        return {"&lt;", 32'h0};
            ENT_GT:        return {"&gt;", 32'h0};
            ENT_QUOT:      return {"&quot;", 16'h0};
            ENT_APOS:      return {"&#39;", 24'h0};
            ENT_AACUTE:    return "&aacute;";
            ENT_EACUTE:    return "&eacute;";
            ENT_IACUTE:    return "&iacute;";
            ENT_OACUTE:    return "&oacute;";
            ENT_UACUTE:    return "&uacute;";
            ENT_NTILDE:    return "&ntilde;";
            ENT_NTILDE_UC: return "&Ntilde;";
            default:       return 64'h0;
        endcase
    endfunction

    function automatic logic [3:0] ent_len(ent_id_t id);
        case (id)
            ENT_AMP:  return 4'd5;
            ENT_LT:   return 4'd4;
            ENT_GT:   return 4'd4;
            ENT_QUOT: return 4'd6;
            ENT_APOS: return 4'd5;
            default:  return 4'd8;
        endcase
    endfunction

    function automatic logic [7:0] ent_char(ent_id_t id, logic [2:0] k);
        logic [63:0] t;
        t = ent_text(id) << {k, 3'b000};
        return t[63:56];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ehe_front.sv =====
// Front end: takes input bytes, tracks a held 0xC3 lead, classifies each byte into a run.
// Depends on ehe_pkg.
`default_nettype none

module ehe_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [7:0]  byte_in,
    input  wire logic        end_of_text,
    input  wire logic        q_full,
    output logic             in_stall,
    output logic             push,
    output ehe_pkg::run_t    run
);
    import ehe_pkg::*;

    logic lead_reg;
    logic lead_next;
    logic accept;
    logic accent_hit;
    ent_id_t accent_id;
    logic hold;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        accent_hit = 1'b1;
        accent_id  = ENT_AACUTE;
        case (byte_in)
            CH_A_ACU: accent_id = ENT_AACUTE;
            CH_E_ACU: accent_id = ENT_EACUTE;
            CH_I_ACU: accent_id = ENT_IACUTE;
            CH_O_ACU: accent_id = ENT_OACUTE;
            CH_U_ACU: accent_id = ENT_UACUTE;
            CH_N_TIL: accent_id = ENT_NTILDE;
            CH_N_TUC: accent_id = ENT_NTILDE_UC;
            default:  accent_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        run.pre  = 1'b0;
        run.post = 1'b0;
        run.kind = BODY_BYTE;
        run.ent  = ENT_AMP;
        run.data = byte_in;
        hold     = 1'b0;
        if (lead_reg && accent_hit)
        begin
            run.kind = BODY_ENT;
            run.ent  = accent_id;
        end
        else
        begin
            run.pre = lead_reg;
            case (byte_in)
                CH_AMP:  begin run.kind = BODY_ENT; run.ent = ENT_AMP;  end
                CH_LT:   begin run.kind = BODY_ENT; run.ent = ENT_LT;   end
                CH_GT:   begin run.kind = BODY_ENT; run.ent = ENT_GT;   end
                CH_QUOT: begin run.kind = BODY_ENT; run.ent = ENT_QUOT; end
                CH_APOS: begin run.kind = BODY_ENT; run.ent = ENT_APOS; end
                CH_LEAD: begin run.kind = BODY_NONE; hold = 1'b1;       end
                default: run.kind = BODY_BYTE;
            endcase
        end
        // lead left over at end of text goes out raw
        if (end_of_text && hold)
        begin
            run.post = 1'b1;
            hold     = 1'b0;
        end
        lead_next = hold;
    end

    assign push = accept && (run.pre || run.post || (run.kind != BODY_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lead_reg <= 1'b0;
        else if (accept)
            lead_reg <= lead_next;
    end

endmodule

`default_nettype wire

// ===== hdl/ehe_queue.sv =====
// Small register FIFO between front and back end.
// No package dependencies.
`default_nettype none

module ehe_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2     // 2 or more
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      rd_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ehe_back.sv =====
// Back end: walks the head run into the output register, one byte per unstalled cycle.
// Depends on ehe_pkg.
`default_nettype none

module ehe_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  ehe_pkg::run_t      head,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         byte_out,
    output logic               run_last
);
    import ehe_pkg::*;

    logic [3:0] pos_reg;
    logic [3:0] body_len;
    logic [3:0] total;
    logic [3:0] k;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       emit;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    always_comb
    begin
        case (head.kind)
            BODY_BYTE: body_len = 4'd1;
            BODY_ENT:  body_len = ent_len(head.ent);
            default:   body_len = 4'd0;
        endcase
        total    = body_len + {3'b000, head.pre} + {3'b000, head.post};
        k        = pos_reg - {3'b000, head.pre};
        cur_last = (pos_reg == total - 4'd1);
        if (head.pre && pos_reg == 4'd0)
            cur_byte = CH_LEAD;
        else if (k < body_len)
            cur_byte = (head.kind == BODY_ENT) ? ent_char(head.ent, k[2:0]) : head.data;
        else
            cur_byte = CH_LEAD;
    end

    assign emit      = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = emit && cur_last;
    assign out_valid = out_valid_reg;
    assign byte_out  = byte_reg;
    assign run_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                pos_reg <= cur_last ? 4'd0 : pos_reg + 4'd1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= cur_byte;
            last_reg <= cur_last;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/html_entity_escaper.sv =====
// HTML entity escaper, top level: front end, run queue, back end.
// Depends on ehe_pkg, ehe_front, ehe_queue, ehe_back.
//
// Usage:
//   Input channel (in_valid/in_stall, byte_in, end_of_text) takes one text byte per
//   transfer; end_of_text marks the last byte of a text. Output channel
//   (out_valid/out_stall, byte_out, run_last) gives one escaped byte per transfer,
//   with run_last set on the final byte of each queued run.
//   & < > " ' become &amp; &lt; &gt; &quot; &#39;. A 0xC3 lead is held; followed
//   by A1 A9 AD B3 BA B1 91 the pair becomes the accented-letter entity, else the
//   0xC3 goes out raw and the next byte is handled normally. A lead still held at
//   end of text goes out raw in the same run. A held lead alone gives no output.
// Path: an accepted byte's run is written into the run queue, and its first byte
//   is then taken from the queue head into the output register.
// Throughput: one output byte per cycle while out_stall is low, set by the back
//   end's byte walker. Plain bytes sustain one input per cycle while the output is
//   not stalled; an entity run holds the back end until its last byte goes out, and
//   the input stalls once the run queue (QUEUE_DEPTH runs) fills.
// Reset: clears the held lead, the queue, the byte position and the output valid flag.
// Output stall: the output register holds its byte; the back end waits and the
//   queue fills, then in_stall rises.
`default_nettype none

module html_entity_escaper #(
    parameter int QUEUE_DEPTH = ehe_pkg::QUEUE_DEPTH   // 2 or more
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] byte_in,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      byte_out,
    output logic            run_last
);
    import ehe_pkg::*;

    localparam int RUN_W = $bits(run_t);

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    run_t run_in;
    run_t run_head;
    logic [RUN_W-1:0] head_bits;

    // classify: one run per input byte, none while only a lead is held
    ehe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .in_stall    (in_stall),
        .push        (push),
        .run         (run_in)
    );

    // decouples input acceptance from multi-byte run emission
    ehe_queue #(
        .WIDTH (RUN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (run_in),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rd_data   (head_bits)
    );

    assign run_head = run_t'(head_bits);

    // emit: one byte per cycle while the output is not stalled, pops the run with its last byte
    ehe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_not_empty),
        .head       (run_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_out   (byte_out),
        .run_last   (run_last)
    );

endmodule

`default_nettype wire
